// File: rtl/assert_macros.svh
// Assertion macros shared by the fixed-point ALU RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/fpa_pkg.sv
// Types, constants and helper functions of the fixed-point ALU.
// Used by every module of the block; depends on nothing.
package fpa_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int WORD_WIDTH = 32;
  localparam int NUM_WIDTH  = WORD_WIDTH + FRAC_BITS;
  localparam int MAG_WIDTH  = (NUM_WIDTH + 1 > 2 * WORD_WIDTH + 1) ?
                              NUM_WIDTH + 1 : 2 * WORD_WIDTH + 1;

  localparam logic [WORD_WIDTH-1:0] MAX_VAL = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] MIN_VAL = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic [MAG_WIDTH-1:0]  NEG_LIM = MAG_WIDTH'(1) << (WORD_WIDTH - 1);
  localparam logic [MAG_WIDTH-1:0]  POS_LIM = NEG_LIM - MAG_WIDTH'(1);
  localparam logic [MAG_WIDTH-1:0]  HALF    = MAG_WIDTH'(1) << (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3,
    OP_GT = 5'd4, OP_LT = 5'd5, OP_GE = 5'd6, OP_LE = 5'd7,
    OP_EQ = 5'd8, OP_NE = 5'd9, OP_MIN = 5'd10, OP_MAX = 5'd11,
    OP_INC = 5'd12, OP_DEC = 5'd13, OP_FROM_INT = 5'd14,
    OP_TO_INT = 5'd15, OP_ABS = 5'd16
  } op_t;

  typedef enum logic [1:0] {ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIV0 = 2'd2} status_t;

  typedef enum logic [1:0] {KIND_SIMPLE, KIND_MUL, KIND_DIV} kind_t;

  typedef struct packed {
    logic [4:0]                   cmd;
    logic signed [WORD_WIDTH-1:0] operand_a;
    logic signed [WORD_WIDTH-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] result_value;
    logic                         compare_true;
    logic [1:0]                   status;
  } rsp_t;

  typedef struct packed {
    logic                      valid;
    kind_t                     kind;
    logic                      neg;
    rsp_t                      simple;
    logic [2*WORD_WIDTH-1:0]   prod;
    logic [WORD_WIDTH-1:0]     den;
    logic [NUM_WIDTH-1:0]      num;
    logic [WORD_WIDTH-1:0]     rem;
    logic [NUM_WIDTH-1:0]      quo;
  } pipe_t;

  // {saturated, value} from a sign and a magnitude
  function automatic logic [WORD_WIDTH:0] sat_mag(input logic neg,
                                                  input logic [MAG_WIDTH-1:0] m);
    logic [WORD_WIDTH-1:0] low;
    low = m[WORD_WIDTH-1:0];
    if (neg) begin
      if (m > NEG_LIM) return {1'b1, MIN_VAL};
      return {1'b0, -low};
    end
    if (m > POS_LIM) return {1'b1, MAX_VAL};
    return {1'b0, low};
  endfunction

  // {saturated, value} from a one-bit-wider signed sum
  function automatic logic [WORD_WIDTH:0] sat_sum(input logic [WORD_WIDTH:0] s);
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
      return {1'b1, (s[WORD_WIDTH] ? MIN_VAL : MAX_VAL)};
    end
    return {1'b0, s[WORD_WIDTH-1:0]};
  endfunction

endpackage

// File: rtl/fpa_front.sv
// Entry stage: decodes the request, finishes the simple operations,
// registers the multiplier product and sets up the divide. Uses fpa_pkg.
module fpa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           req_valid,
  input  fpa_pkg::req_t  req,
  output fpa_pkg::pipe_t stage
);
  import fpa_pkg::*;

  localparam int W = WORD_WIDTH;

  pipe_t           stage_next;
  logic [W-1:0]    a, b, ma, mb;
  logic [W:0]      ea, eb;
  logic [W:0]      sum_r, dif_r, inc_r, dec_r, fi_r;
  logic            lt, gt, eq;
  logic [FRAC_BITS:0] top;

  always_comb begin
    a  = req.operand_a;
    b  = req.operand_b;
    ea = {a[W-1], a};
    eb = {b[W-1], b};
    ma = a[W-1] ? -a : a;
    mb = b[W-1] ? -b : b;
    lt = $signed(a) < $signed(b);
    gt = $signed(b) < $signed(a);
    eq = a == b;
    sum_r = sat_sum(ea + eb);
    dif_r = sat_sum(ea - eb);
    inc_r = sat_sum(ea + (W+1)'(1));
    dec_r = sat_sum(ea - (W+1)'(1));
    top   = a[W-1 -: FRAC_BITS+1];
    fi_r  = ((&top) || !(|top)) ? {1'b0, a << FRAC_BITS} :
                                  {1'b1, (a[W-1] ? MIN_VAL : MAX_VAL)};

    stage_next.valid = req_valid;
    stage_next.kind  = KIND_SIMPLE;
    stage_next.neg   = a[W-1] ^ b[W-1];
    stage_next.prod  = ma * mb;
    stage_next.den   = mb;
    stage_next.num   = {ma, {FRAC_BITS{1'b0}}};
    stage_next.rem   = '0;
    stage_next.quo   = '0;
    stage_next.simple = '0;

    unique case (req.cmd)
      OP_ADD: begin
        stage_next.simple.result_value = sum_r[W-1:0];
        stage_next.simple.status = sum_r[W] ? ST_SAT : ST_OK;
      end
      OP_SUB: begin
        stage_next.simple.result_value = dif_r[W-1:0];
        stage_next.simple.status = dif_r[W] ? ST_SAT : ST_OK;
      end
      OP_MUL: stage_next.kind = KIND_MUL;
      OP_DIV: begin
        if (b == '0) begin
          stage_next.simple.result_value = a[W-1] ? MIN_VAL : MAX_VAL;
          stage_next.simple.status = ST_DIV0;
        end else begin
          stage_next.kind = KIND_DIV;
        end
      end
      OP_GT: stage_next.simple.compare_true = gt;
      OP_LT: stage_next.simple.compare_true = lt;
      OP_GE: stage_next.simple.compare_true = !lt;
      OP_LE: stage_next.simple.compare_true = !gt;
      OP_EQ: stage_next.simple.compare_true = eq;
      OP_NE: stage_next.simple.compare_true = !eq;
      OP_MIN: stage_next.simple.result_value = lt ? a : b;
      OP_MAX: stage_next.simple.result_value = gt ? a : b;
      OP_INC: begin
        stage_next.simple.result_value = inc_r[W-1:0];
        stage_next.simple.status = inc_r[W] ? ST_SAT : ST_OK;
      end
      OP_DEC: begin
        stage_next.simple.result_value = dec_r[W-1:0];
        stage_next.simple.status = dec_r[W] ? ST_SAT : ST_OK;
      end
      OP_FROM_INT: begin
        stage_next.simple.result_value = fi_r[W-1:0];
        stage_next.simple.status = fi_r[W] ? ST_SAT : ST_OK;
      end
      OP_TO_INT: stage_next.simple.result_value = $signed(a) >>> FRAC_BITS;
      OP_ABS: begin
        if (a == MIN_VAL) begin
          stage_next.simple.result_value = MAX_VAL;
          stage_next.simple.status = ST_SAT;
        end else begin
          stage_next.simple.result_value = ma;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// File: rtl/fpa_cell.sv
// One divide cell: develops one quotient bit by restoring subtraction and
// passes the request on. Uses fpa_pkg.
module fpa_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  fpa_pkg::pipe_t up,
  output fpa_pkg::pipe_t down
);
  import fpa_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int NW = NUM_WIDTH;

  pipe_t      down_next;
  logic [W:0] trial;

  always_comb begin
    trial = {up.rem, up.num[NW-1]} - {1'b0, up.den};
    down_next = up;
    down_next.num = up.num << 1;
    if (!trial[W]) begin
      down_next.rem = trial[W-1:0];
      down_next.quo = {up.quo[NW-2:0], 1'b1};
    end else begin
      down_next.rem = {up.rem[W-2:0], up.num[NW-1]};
      down_next.quo = {up.quo[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (en) begin
      down <= down_next;
    end
  end

endmodule

// File: rtl/fpa_back.sv
// Exit stage: rounds and saturates multiply and divide results, picks the
// answer and holds it in the output register. Uses fpa_pkg.
module fpa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  fpa_pkg::pipe_t up,
  output logic           rsp_valid,
  output fpa_pkg::rsp_t  rsp
);
  import fpa_pkg::*;

  localparam int W = WORD_WIDTH;

  rsp_t                 rsp_next;
  logic [MAG_WIDTH-1:0] mul_m, div_m;
  logic                 round_up;
  logic [W:0]           mul_r, div_r;

  always_comb begin
    mul_m    = (MAG_WIDTH'(up.prod) + HALF) >> FRAC_BITS;
    round_up = {up.rem, 1'b0} >= {1'b0, up.den};
    div_m    = MAG_WIDTH'(up.quo) + MAG_WIDTH'(round_up);
    mul_r    = sat_mag(up.neg, mul_m);
    div_r    = sat_mag(up.neg, div_m);
    rsp_next = up.simple;
    case (up.kind)
      KIND_MUL: begin
        rsp_next.result_value = mul_r[W-1:0];
        rsp_next.status = mul_r[W] ? ST_SAT : ST_OK;
      end
      KIND_DIV: begin
        rsp_next.result_value = div_r[W-1:0];
        rsp_next.status = div_r[W] ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= up.valid;
    end
    if (en) rsp <= rsp_next;
  end

endmodule

// File: rtl/q24_8_fixed_point_alu.sv
// Signed Q24.8 fixed-point ALU: takes one request per cycle unless stalled and
// returns one response per request, in order, through one entry stage, a row
// of 40 divide cells, one bit each, and the output register. The divide cell
// row sets the latency for every opcode.
// A stalled response stalls the whole row; no requests are dropped.
// Depends on fpa_pkg, fpa_front, fpa_cell, fpa_back and assert_macros.svh.
`include "assert_macros.svh"

module q24_8_fixed_point_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fpa_pkg::rsp_t rsp
);
  import fpa_pkg::*;

  logic  en;
  pipe_t chain [0:NUM_WIDTH];

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  fpa_front u_front (
    .clk, .rst, .en, .req_valid, .req, .stage(chain[0])
  );

  for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_cell
    fpa_cell u_cell (
      .clk, .rst, .en, .up(chain[i]), .down(chain[i+1])
    );
  end

  fpa_back u_back (
    .clk, .rst, .en, .up(chain[NUM_WIDTH]), .rsp_valid, .rsp
  );

  `ASSERT_IMPLIES(a_cmp_zero, clk, rst, rsp_valid && rsp.compare_true, rsp.result_value == '0)
  `ASSERT_IMPLIES(a_div0_bound, clk, rst, rsp_valid && rsp.status == ST_DIV0, (rsp.result_value == MAX_VAL || rsp.result_value == MIN_VAL))
  `ASSERT_IMPLIES(a_sat_bound, clk, rst, rsp_valid && rsp.status == ST_SAT, (rsp.result_value == MAX_VAL || rsp.result_value == MIN_VAL))
  `ASSERT_NEXT(a_stall_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

// File: tb/q24_8_fixed_point_alu_tb.sv
// Self-checking testbench of the Q24.8 fixed-point ALU: a directed table, then
// random requests under three idle patterns, checked against a local predictor.
// Depends on fpa_pkg and q24_8_fixed_point_alu.
`timescale 1ns / 1ps

module q24_8_fixed_point_alu_tb;
  import fpa_pkg::*;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  rsp_t alu_expect_q[$];
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  row_t dir_rows[$];

  always #5 clk = ~clk;

  q24_8_fixed_point_alu u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  function automatic rsp_t from_mag(logic neg, logic [63:0] m);
    rsp_t o;
    o = '0;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        o.result_value = MIN_VAL;
        o.status = ST_SAT;
      end else begin
        o.result_value = -m[31:0];
      end
    end else if (m > 64'h7fff_ffff) begin
      o.result_value = MAX_VAL;
      o.status = ST_SAT;
    end else begin
      o.result_value = m[31:0];
    end
    return o;
  endfunction

  function automatic rsp_t alu_predict(req_t r);
    rsp_t o;
    logic signed [32:0] s;
    logic signed [31:0] a, b;
    logic [63:0] ma, mb, num, quo, remd;
    logic neg;
    o = '0;
    a = r.operand_a;
    b = r.operand_b;
    ma = a[31] ? -{{32{a[31]}}, a} : {32'd0, a};
    mb = b[31] ? -{{32{b[31]}}, b} : {32'd0, b};
    neg = a[31] ^ b[31];
    s = '0;
    case (op_t'(r.cmd))
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        case (op_t'(r.cmd))
          OP_ADD: s = {a[31], a} + {b[31], b};
          OP_SUB: s = {a[31], a} - {b[31], b};
          OP_INC: s = {a[31], a} + 33'sd1;
          default: s = {a[31], a} - 33'sd1;
        endcase
        if (s[32] != s[31]) begin
          o.result_value = s[32] ? MIN_VAL : MAX_VAL;
          o.status = ST_SAT;
        end else begin
          o.result_value = s[31:0];
        end
      end
      OP_MUL: o = from_mag(neg, (ma * mb + 64'd128) >> 8);
      OP_DIV: begin
        if (b == 0) begin
          o.result_value = a[31] ? MIN_VAL : MAX_VAL;
          o.status = ST_DIV0;
        end else begin
          num = ma << 8;
          quo = num / mb;
          remd = num % mb;
          if (remd >= mb - remd) quo = quo + 1;
          o = from_mag(neg, quo);
        end
      end
      OP_GT: o.compare_true = a > b;
      OP_LT: o.compare_true = a < b;
      OP_GE: o.compare_true = a >= b;
      OP_LE: o.compare_true = a <= b;
      OP_EQ: o.compare_true = a == b;
      OP_NE: o.compare_true = a != b;
      OP_MIN: o.result_value = (a < b) ? a : b;
      OP_MAX: o.result_value = (a > b) ? a : b;
      OP_FROM_INT: o = from_mag(a[31], ma << 8);
      OP_TO_INT: o.result_value = a >>> 8;
      OP_ABS: o = from_mag(1'b0, ma);
      default: o = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic send_request(req_t r, rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    alu_expect_q.push_back(want);
    n_sent++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(6))
      0: return 32'($urandom_range(2047)) - 32'd1024;
      1: return MAX_VAL;
      2: return MIN_VAL;
      3: return 32'($signed($urandom) >>> $urandom_range(31));
      4: return $urandom_range(1) ? 32'd0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (alu_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected response %h", rsp));
      end else begin
        rsp_t w;
        w = alu_expect_q.pop_front();
        n_checked++;
        if (rsp.result_value !== w.result_value)
          report_mismatch($sformatf("result_value %h, want %h", rsp.result_value,
                                    w.result_value));
        if (rsp.compare_true !== w.compare_true)
          report_mismatch($sformatf("compare_true %b, want %b", rsp.compare_true,
                                    w.compare_true));
        if (rsp.status !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp.status, w.status));
      end
    end
    rsp_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic row_t mk(op_t op, logic [31:0] a, logic [31:0] b, bit typed = 0,
                              logic [31:0] v = 0, logic c = 0, status_t st = ST_OK);
    row_t x;
    x.r = '{cmd: op, operand_a: a, operand_b: b};
    x.typed = typed;
    x.want = '{result_value: v, compare_true: c, status: st};
    return x;
  endfunction

  initial begin
    req_t r;
    rsp_t w;
    int phase_pcts[3][2];
    phase_pcts = '{'{38, 84}, '{84, 38}, '{0, 0}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    dir_rows.push_back(mk(OP_ADD, MAX_VAL, 32'd1, 1, MAX_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(OP_SUB, MIN_VAL, 32'd1, 1, MIN_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(OP_MUL, MAX_VAL, MAX_VAL, 1, MAX_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(OP_MUL, MIN_VAL, MAX_VAL, 1, MIN_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(OP_MUL, 32'hffff_fe80, 32'h0000_0080));
    dir_rows.push_back(mk(OP_DIV, 32'd5, 32'd0, 1, MAX_VAL, 0, ST_DIV0));
    dir_rows.push_back(mk(OP_DIV, 32'hffff_fff0, 32'd0, 1, MIN_VAL, 0, ST_DIV0));
    dir_rows.push_back(mk(OP_DIV, 32'd0, 32'd0, 1, MAX_VAL, 0, ST_DIV0));
    dir_rows.push_back(mk(OP_DIV, MIN_VAL, 32'hffff_ffff));
    dir_rows.push_back(mk(OP_DIV, 32'h0000_0100, 32'h0000_0300));
    dir_rows.push_back(mk(OP_GT, 32'd3, MIN_VAL, 1, 0, 1));
    dir_rows.push_back(mk(OP_LT, MIN_VAL, MAX_VAL, 1, 0, 1));
    dir_rows.push_back(mk(OP_GE, 32'd7, 32'd7, 1, 0, 1));
    dir_rows.push_back(mk(OP_LE, MAX_VAL, MIN_VAL, 1, 0, 0));
    dir_rows.push_back(mk(OP_EQ, MIN_VAL, MIN_VAL, 1, 0, 1));
    dir_rows.push_back(mk(OP_NE, 32'd1, 32'd1, 1, 0, 0));
    dir_rows.push_back(mk(OP_MIN, MIN_VAL, MAX_VAL, 1, MIN_VAL));
    dir_rows.push_back(mk(OP_MAX, MIN_VAL, MAX_VAL, 1, MAX_VAL));
    dir_rows.push_back(mk(OP_INC, MAX_VAL, 32'd0, 1, MAX_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(OP_DEC, MIN_VAL, 32'd0, 1, MIN_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(OP_FROM_INT, 32'h0080_0000, 32'd0, 1, MAX_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(OP_FROM_INT, 32'hff80_0000, 32'd0, 1, MIN_VAL, 0, ST_OK));
    dir_rows.push_back(mk(OP_TO_INT, 32'hffff_ffff, 32'd0, 1, 32'hffff_ffff));
    dir_rows.push_back(mk(OP_ABS, MIN_VAL, 32'd0, 1, MAX_VAL, 0, ST_SAT));
    dir_rows.push_back(mk(op_t'(5'd31), MAX_VAL, MAX_VAL, 1, 32'd0));

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = phase_pcts[p][0];
      recv_idle_pct = phase_pcts[p][1];
      if (p == 0) begin
        foreach (dir_rows[i])
          send_request(dir_rows[i].r,
                       dir_rows[i].typed ? dir_rows[i].want : alu_predict(dir_rows[i].r));
      end
      for (int i = 0; i < 500; i++) begin
        r.cmd = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
                                         : 5'($urandom_range(16));
        r.operand_a = pick_operand();
        r.operand_b = pick_operand();
        w = alu_predict(r);
        send_request(r, w);
      end
    end
    req_valid <= 1'b0;
    while (alu_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests (directed table plus random) under three idle patterns;",
             n_sent);
    $display("%0d responses checked, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && alu_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d responses outstanding", alu_expect_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
